// ===== hw/rtl/jrd_pkg.sv =====
// Package for the radial deadzone joystick block.
// Holds sizes, reset values, direction and register codes, the sequencer
// states and the CORDIC arctangent table. No dependencies.
package jrd_pkg;

   localparam int STICK_COUNT = 2;

   localparam logic [14:0] LEFT_DZ_RESET  = 15'd7849;
   localparam logic [14:0] RIGHT_DZ_RESET = 15'd8689;
   localparam logic [14:0] MAG_MAX        = 15'd32767;
   localparam logic [23:0] MAG_CLAMP      = 24'd8388352;   // 32767 in Q.8
   localparam logic [16:0] NORM_SAT       = 17'd16385;
   localparam logic [16:0] LEN_MAX        = 17'd32768;
   localparam logic signed [17:0] ANG_PI       = 18'sd32768;
   localparam logic signed [17:0] ANG_NEG_LIM  = -18'sd32767;
   localparam logic signed [17:0] ANG_HALF_PI  = 18'sd16384;

   localparam logic [4:0] SQRT_STEPS = 5'd24;
   localparam logic [4:0] DIV_STEPS  = 5'd17;
   localparam logic [4:0] CORD_STEPS = 5'd15;

   typedef enum logic [2:0] {
      DIR_CENTER = 3'd0,
      DIR_UP     = 3'd1,
      DIR_DOWN   = 3'd2,
      DIR_LEFT   = 3'd3,
      DIR_RIGHT  = 3'd4
   } dir_type;

   localparam logic REG_LEFT_DZ  = 1'b0;
   localparam logic REG_RIGHT_DZ = 1'b1;

   typedef enum logic [10:0] {
      ST_IDLE = 11'b00000000001,
      ST_MULX = 11'b00000000010,
      ST_MULY = 11'b00000000100,
      ST_MULD = 11'b00000001000,
      ST_CMP  = 11'b00000010000,
      ST_SQRT = 11'b00000100000,
      ST_DIVX = 11'b00001000000,
      ST_DIVY = 11'b00010000000,
      ST_DIVL = 11'b00100000000,
      ST_CORD = 11'b01000000000,
      ST_DONE = 11'b10000000000
   } state_type;

   // atan(2^-i) in units of pi/32768
   function automatic logic [13:0] atan_lut(input logic [3:0] i);
      logic [13:0] v;
      unique case (i)
         4'd0:    v = 14'd8192;
         4'd1:    v = 14'd4836;
         4'd2:    v = 14'd2555;
         4'd3:    v = 14'd1297;
         4'd4:    v = 14'd651;
         4'd5:    v = 14'd326;
         4'd6:    v = 14'd163;
         4'd7:    v = 14'd81;
         4'd8:    v = 14'd41;
         4'd9:    v = 14'd20;
         4'd10:   v = 14'd10;
         4'd11:   v = 14'd5;
         4'd12:   v = 14'd3;
         4'd13:   v = 14'd1;
         4'd14:   v = 14'd1;
         default: v = 14'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== hw/rtl/joystick_radial_deadzone.sv =====
// Radial deadzone joystick normalizer, top level.
// Uses jrd_pkg. One 17x17 multiplier, one shared subtract/compare unit
// (square root and divisions) and a CORDIC datapath under one sequencer.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+---------------------------------
//  req     | in  | req_tvalid/req_tready  | tdata x_pos,y_pos; tuser stick
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata 104 bits, fields below
//  csr     | in  | csr_valid/csr_ready    | csr_index, csr_data (15 bits)
//
// An item goes through 3 multiplies, 1 compare, 24 square root steps,
// 3 x 17 divide steps (the length divide is skipped at deadzone 32767) and
// 15 CORDIC steps, one after another. An item inside the deadzone
// finishes after the compare. req_tready is high only in idle. A finished
// beat waits in the output register; the next beat can be accepted
// meanwhile and stalls at its end only if the previous result is not taken.
// Reset is synchronous: deadzones return to their reset values, every
// stick's last direction to center, the sequencer to idle.
module joystick_radial_deadzone
   import jrd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // x_pos[15:0], y_pos[31:16]
   input  logic         req_tuser,   // stick_select
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // x_out[15:0], y_out[31:16], norm_x[47:32], norm_y[63:48],
   // scaled_length[79:64], stick_angle[96:80], direction[99:97],
   // direction_changed[100], zero pad[103:101]
   output logic [103:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [14:0]  csr_data
);

   state_type state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        sel_ff, sel_in;
   logic signed [15:0] x_ff, x_in, y_ff, y_in;
   logic signed [33:0] prod_ff, prod_in;
   logic [31:0] ss_ff, ss_in;
   logic [47:0] rad_ff, rad_in;
   logic [26:0] rem_ff, rem_in;
   logic [23:0] q_ff, q_in;
   logic [23:0] div_ff, div_in;
   logic [16:0] nsh_ff, nsh_in;
   logic [23:0] mag_ff, mag_in;
   logic [15:0] nx_ff, nx_in, ny_ff, ny_in, len_ff, len_in;
   logic signed [32:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [17:0] cz_ff, cz_in;
   logic [2:0]  dir_ff, dir_in;
   logic        out_ff, out_in;
   logic [2:0]  last_dir_ff [STICK_COUNT];
   logic [14:0] left_dz_ff, right_dz_ff;
   logic        rsp_valid_ff;
   logic [103:0] rsp_data_ff;

   // operand views
   logic [14:0] dz;
   logic signed [16:0] xs, ys, nxs, nys;
   logic [16:0] ax, ay;
   logic signed [16:0] mul_a, mul_b;
   logic signed [33:0] prod;
   logic [26:0] sub_a, sub_b;
   logic [27:0] diff;
   logic        ge;
   logic [23:0] q_step;
   logic [26:0] rem_step;
   logic [23:0] mag_clamped;
   logic [23:0] dz_q8, d_len;
   logic [14:0] len_div;
   logic [2:0]  dir_calc;
   logic signed [32:0] cx0, cy0, dxs, dys;
   logic signed [17:0] cz0, cz_step;
   logic [13:0] atan_v;
   logic signed [17:0] angle;
   logic [15:0] norm_res;
   logic [16:0] len_res;
   logic        take_out;
   logic        chg;

   function automatic logic [15:0] norm_finish(input logic [16:0] q, input logic neg);
      logic [16:0] r;
      r = (q + 17'd1) >> 1;
      if (r > NORM_SAT) r = NORM_SAT;
      return neg ? (16'd0 - r[15:0]) : r[15:0];
   endfunction

   assign dz  = sel_ff ? right_dz_ff : left_dz_ff;
   assign xs  = {x_ff[15], x_ff};
   assign ys  = {y_ff[15], y_ff};
   assign nxs = -xs;
   assign nys = -ys;
   assign ax  = x_ff[15] ? nxs : xs;
   assign ay  = y_ff[15] ? nys : ys;

   // sector with the 45 and 135 degree boundaries as specified
   always_comb begin
      priority if (ys > 0 && ys >= xs && ys > nxs)      dir_calc = DIR_UP;
      else if (ys < 0 && nys > xs && ys <= xs)          dir_calc = DIR_DOWN;
      else if (xs < 0 && ((ys >= 0 && ys <= nxs) || (ys < 0 && ys > xs)))
                                                        dir_calc = DIR_LEFT;
      else                                              dir_calc = DIR_RIGHT;
   end

   // shared multiplier
   always_comb begin
      unique case (1'b1)
         state_ff[2]: begin mul_a = ys; mul_b = ys; end
         state_ff[3]: begin mul_a = {2'b00, dz}; mul_b = {2'b00, dz}; end
         default:     begin mul_a = xs; mul_b = xs; end
      endcase
   end
   assign prod = mul_a * mul_b;

   // shared subtract/compare: square root trial or restoring divide step
   always_comb begin
      if (state_ff == ST_SQRT) begin
         sub_a = {rem_ff[24:0], rad_ff[47:46]};
         sub_b = {1'b0, q_ff, 2'b01};
      end else begin
         sub_a = {2'b00, rem_ff[23:0], nsh_ff[16]};
         sub_b = {3'b000, div_ff};
      end
   end
   assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
   assign ge       = ~diff[27];
   assign q_step   = {q_ff[22:0], ge};
   assign rem_step = ge ? diff[26:0] : sub_a;

   assign mag_clamped = (q_step > MAG_CLAMP) ? MAG_CLAMP : q_step;
   assign dz_q8   = {1'b0, dz, 8'd0};
   assign d_len   = mag_ff - dz_q8;
   assign len_div = MAG_MAX - dz;

   assign norm_res = norm_finish(q_step[16:0], (state_ff == ST_DIVX) ? x_ff[15] : y_ff[15]);
   assign len_res  = ((q_step[16:0] + 17'd1) >> 1) > LEN_MAX ? LEN_MAX
                   : ((q_step[16:0] + 17'd1) >> 1);

   // CORDIC: quadrant reduction, then one micro-rotation per cycle
   always_comb begin
      if (x_ff[15]) begin
         if (ys > 0) begin
            cx0 = 33'(ys) <<< 14; cy0 = 33'(nxs) <<< 14; cz0 = ANG_HALF_PI;
         end else begin
            cx0 = 33'(nys) <<< 14; cy0 = 33'(xs) <<< 14; cz0 = -ANG_HALF_PI;
         end
      end else begin
         cx0 = 33'(xs) <<< 14; cy0 = 33'(ys) <<< 14; cz0 = 18'sd0;
      end
   end
   assign dxs    = cy_ff >>> cnt_ff[3:0];
   assign dys    = cx_ff >>> cnt_ff[3:0];
   assign atan_v = atan_lut(cnt_ff[3:0]);
   assign cz_step = (cy_ff > 0) ? cz_ff + $signed({4'd0, atan_v})
                                : cz_ff - $signed({4'd0, atan_v});

   // exact on the axes, clamped elsewhere
   always_comb begin
      priority if (y_ff == 16'sd0) angle = (x_ff > 16'sd0) ? 18'sd0 : ANG_PI;
      else if (x_ff == 16'sd0)     angle = (y_ff > 16'sd0) ? ANG_HALF_PI : -ANG_HALF_PI;
      else if (cz_ff > ANG_PI)     angle = ANG_PI;
      else if (cz_ff < ANG_NEG_LIM) angle = ANG_NEG_LIM;
      else                         angle = cz_ff;
   end

   assign take_out = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign chg      = (dir_ff != last_dir_ff[sel_ff]);

   // sequencer
   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; sel_in = sel_ff;
      x_in = x_ff; y_in = y_ff; prod_in = prod_ff; ss_in = ss_ff;
      rad_in = rad_ff; rem_in = rem_ff; q_in = q_ff; div_in = div_ff;
      nsh_in = nsh_ff; mag_in = mag_ff; nx_in = nx_ff; ny_in = ny_ff;
      len_in = len_ff; cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff;
      dir_in = dir_ff; out_in = out_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               x_in = req_tdata[15:0];
               y_in = req_tdata[31:16];
               sel_in = req_tuser;
               state_in = ST_MULX;
            end
         end
         ST_MULX: begin
            prod_in = prod;
            state_in = ST_MULY;
         end
         ST_MULY: begin
            ss_in = prod_ff[31:0];
            prod_in = prod;
            state_in = ST_MULD;
         end
         ST_MULD: begin
            ss_in = ss_ff + prod_ff[31:0];
            prod_in = prod;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            out_in = ss_ff > prod_ff[31:0];
            dir_in = out_in ? dir_calc : DIR_CENTER;
            rad_in = {ss_ff, 16'd0};
            rem_in = '0;
            q_in = '0;
            cnt_in = '0;
            state_in = out_in ? ST_SQRT : ST_DONE;
         end
         ST_SQRT: begin
            rad_in = rad_ff << 2;
            rem_in = rem_step;
            q_in = q_step;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == SQRT_STEPS - 5'd1) begin
               mag_in = mag_clamped;
               div_in = mag_clamped;
               rem_in = {4'd0, ax, 6'd0};
               q_in = '0;
               nsh_in = '0;
               cnt_in = '0;
               state_in = ST_DIVX;
            end
         end
         ST_DIVX, ST_DIVY: begin
            rem_in = rem_step;
            q_in = q_step;
            nsh_in = nsh_ff << 1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == DIV_STEPS - 5'd1) begin
               q_in = '0;
               cnt_in = '0;
               if (state_ff == ST_DIVX) begin
                  nx_in = norm_res;
                  rem_in = {4'd0, ay, 6'd0};
                  nsh_in = '0;
                  state_in = ST_DIVY;
               end else begin
                  ny_in = norm_res;
                  div_in = {9'd0, len_div};
                  rem_in = {13'd0, d_len[22:9]};
                  nsh_in = {d_len[8:0], 8'd0};
                  if (len_div == 15'd0) begin
                     len_in = LEN_MAX[15:0];
                     cx_in = cx0; cy_in = cy0; cz_in = cz0;
                     state_in = ST_CORD;
                  end else begin
                     state_in = ST_DIVL;
                  end
               end
            end
         end
         ST_DIVL: begin
            rem_in = rem_step;
            q_in = q_step;
            nsh_in = nsh_ff << 1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == DIV_STEPS - 5'd1) begin
               len_in = len_res[15:0];
               cnt_in = '0;
               cx_in = cx0; cy_in = cy0; cz_in = cz0;
               state_in = ST_CORD;
            end
         end
         ST_CORD: begin
            if (cy_ff > 0) begin
               cx_in = cx_ff + dxs; cy_in = cy_ff - dys;
            end else begin
               cx_in = cx_ff - dxs; cy_in = cy_ff + dys;
            end
            cz_in = cz_step;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == CORD_STEPS - 5'd1) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (take_out) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         left_dz_ff <= LEFT_DZ_RESET;
         right_dz_ff <= RIGHT_DZ_RESET;
         for (int i = 0; i < STICK_COUNT; i++) last_dir_ff[i] <= DIR_CENTER;
      end else begin
         state_ff <= state_in;
         if (take_out) begin
            rsp_valid_ff <= 1'b1;
            last_dir_ff[sel_ff] <= dir_ff;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            unique case (csr_index)
               REG_LEFT_DZ:  left_dz_ff <= csr_data;
               REG_RIGHT_DZ: right_dz_ff <= csr_data;
               default:      ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in; sel_ff <= sel_in; x_ff <= x_in; y_ff <= y_in;
      prod_ff <= prod_in; ss_ff <= ss_in; rad_ff <= rad_in; rem_ff <= rem_in;
      q_ff <= q_in; div_ff <= div_in; nsh_ff <= nsh_in; mag_ff <= mag_in;
      nx_ff <= nx_in; ny_ff <= ny_in; len_ff <= len_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
      dir_ff <= dir_in; out_ff <= out_in;
      if (take_out) begin
         if (out_ff)
            rsp_data_ff <= {3'd0, chg, dir_ff, angle[16:0], len_ff, ny_ff, nx_ff,
                            y_ff, x_ff};
         else
            rsp_data_ff <= {3'd0, chg, DIR_CENTER, 97'd0};
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

endmodule

// ===== tb/joystick_radial_deadzone_test.sv =====
// Self-checking bench for the radial deadzone joystick normalizer.
// Depends on jrd_pkg and joystick_radial_deadzone; predicts every result beat
// in-bench and compares it field by field, under random stalls on both sides.
module joystick_radial_deadzone_test;
   import jrd_pkg::*;

   typedef struct packed {
      logic        changed;
      dir_type     dir;
      logic [16:0] angle;
      logic [15:0] length;
      logic [15:0] ny;
      logic [15:0] nx;
      logic [15:0] yo;
      logic [15:0] xo;
   } stick_result_type;

   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 200;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_index = 1'b0;
   logic [14:0]  csr_data = '0;

   joystick_radial_deadzone dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state: deadzones and last direction per stick
   logic [14:0]      dz_left, dz_right;
   dir_type          prev_dir [STICK_COUNT];
   stick_result_type pending_results[$];
   int               fail_count = 0;
   int               beats_sent = 0;
   int               beats_checked = 0;
   int               idle_cycles = 0;
   int               inside_seen = 0;
   int               gap_left = 0;     // sender gap countdown
   logic             stall_mode = 1'b0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      fail_count++;
      $display("mismatch beat %0d %s: got %0h want %0h", beats_checked, what, got, want);
   endtask

   function automatic longint shr_floor(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic longint cordic_angle(input longint x, input longint y);
      longint cx, cy, z, t, dx, dy;
      int atab [15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
      if (y == 0) return (x > 0) ? 0 : 32768;
      if (x == 0) return (y > 0) ? 16384 : -16384;
      cx = x; cy = y; z = 0;
      if (x < 0) begin
         t = cx;
         if (y > 0) begin cx = cy; cy = -t; z = 16384; end
         else begin cx = -cy; cy = t; z = -16384; end
      end
      cx *= 16384; cy *= 16384;
      for (int i = 0; i < 15; i++) begin
         dx = shr_floor(cy, i); dy = shr_floor(cx, i);
         if (cy > 0) begin cx += dx; cy -= dy; z += atab[i]; end
         else begin cx -= dx; cy += dy; z -= atab[i]; end
      end
      if (z > 32768) z = 32768;
      if (z < -32767) z = -32767;
      return z;
   endfunction

   function automatic longint unsigned root_floor(input longint unsigned v);
      longint unsigned res, b;
      res = 0; b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin v -= res + b; res = (res >> 1) + b; end
         else res >>= 1;
         b >>= 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] unit_axis(input longint v, input longint unsigned mag);
      longint unsigned a, q;
      a = (v < 0) ? -v : v;
      q = (((a << 23) / mag) + 1) >> 1;
      if (q > 16385) q = 16385;
      return (v < 0) ? 16'(-q) : 16'(q);
   endfunction

   // works out the expected beat and updates the stick's last direction
   function automatic stick_result_type normalize_sample(input logic sel,
                                                         input logic [15:0] xr,
                                                         input logic [15:0] yr);
      stick_result_type r;
      longint x, y;
      longint unsigned ss, dz, mag, num, den, len;
      dir_type d;
      x = longint'($signed(xr)); y = longint'($signed(yr));
      dz = sel ? dz_right : dz_left;
      ss = x * x + y * y;
      r = '0;
      d = DIR_CENTER;
      if (ss > dz * dz) begin
         mag = root_floor(ss << 16);
         if (mag > 64'd8388352) mag = 64'd8388352;
         r.xo = xr; r.yo = yr;
         r.nx = unit_axis(x, mag);
         r.ny = unit_axis(y, mag);
         den = (64'd32767 - dz) << 8;
         if (den == 0) len = 32768;
         else begin
            num = (mag - (dz << 8)) * 32768;
            len = ((2 * num) / den + 1) >> 1;
            if (len > 32768) len = 32768;
         end
         r.length = len[15:0];
         r.angle = 17'(cordic_angle(x, y));
         if (y > 0 && y >= x && y > -x) d = DIR_UP;
         else if (y < 0 && -y > x && y <= x) d = DIR_DOWN;
         else if (x < 0 && ((y >= 0 && y <= -x) || (y < 0 && y > x))) d = DIR_LEFT;
         else d = DIR_RIGHT;
      end
      r.dir = d;
      r.changed = (d != prev_dir[sel]);
      prev_dir[sel] = d;
      return r;
   endfunction

   // result checker, plus the receiver stall pattern and watchdog
   always @(posedge clock) begin
      stick_result_type got, want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            got = stick_result_type'(rsp_tdata[100:0]);
            if (rsp_tdata[103:101] != 3'b000) report("pad", rsp_tdata[103:101], 0);
            if (pending_results.size() == 0) begin
               report("unexpected beat", 0, 0);
            end else begin
               want = pending_results.pop_front();
               if (got.xo != want.xo) report("x_out", got.xo, want.xo);
               if (got.yo != want.yo) report("y_out", got.yo, want.yo);
               if (got.nx != want.nx) report("norm_x", got.nx, want.nx);
               if (got.ny != want.ny) report("norm_y", got.ny, want.ny);
               if (got.length != want.length) report("scaled_length", got.length, want.length);
               if (got.angle != want.angle) report("stick_angle", got.angle, want.angle);
               if (got.dir != want.dir) report("direction", got.dir, want.dir);
               if (got.changed != want.changed)
                  report("direction_changed", got.changed, want.changed);
               if (want.dir == DIR_CENTER) inside_seen++;
            end
            beats_checked++;
         end
         // receiver: stretches of free flow alternate with random stalls
         if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
         rsp_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   // one register write; csr_valid is dropped again before the task returns
   task automatic write_reg(input logic idx, input logic [14:0] val);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_LEFT_DZ) dz_left = val; else dz_right = val;
      @(posedge clock);
   endtask

   // one sample beat; gaps come in bursts, the predictor runs on acceptance
   task automatic send_sample(input logic sel, input logic [15:0] xr, input logic [15:0] yr);
      if (gap_left > 0) begin
         repeat (gap_left) @(posedge clock);
         gap_left = 0;
      end
      req_tvalid <= 1'b1; req_tuser <= sel; req_tdata <= {yr, xr};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(normalize_sample(sel, xr, yr));
      beats_sent++;
      if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 40);
      if (gap_left > 0) req_tvalid <= 1'b0;
   endtask

   task automatic drain();
      // a pending gap means the last send already dropped tvalid
      if (gap_left == 0) req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // inside-deadzone items also return a beat, so the queue above covers them too
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed();
      logic [15:0] edge_vals [8] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
                                     16'h1000, 16'hF000, 16'h2EA9};
      // axes, extremes, 45 and 135 degree diagonals, both sticks
      send_sample(1'b0, 16'h7FFF, 16'h0000);
      send_sample(1'b0, 16'h8000, 16'h0000);
      send_sample(1'b0, 16'h0000, 16'h7FFF);
      send_sample(1'b0, 16'h0000, 16'h8000);
      send_sample(1'b0, 16'h8000, 16'h8000);
      send_sample(1'b0, 16'h7FFF, 16'h7FFF);
      send_sample(1'b1, 16'h4000, 16'h4000);
      send_sample(1'b1, 16'hC000, 16'h4000);
      send_sample(1'b1, 16'hC000, 16'hC000);
      send_sample(1'b1, 16'h4000, 16'hC000);
      send_sample(1'b1, 16'h0000, 16'h0000);
      send_sample(1'b0, 16'd7849, 16'h0000);   // exactly on the deadzone edge
      send_sample(1'b0, 16'd7850, 16'h0000);   // just outside: length rounds near zero
      send_sample(1'b1, 16'h7FFF, 16'h8000);
      for (int i = 0; i < 8; i++) send_sample(i[0], edge_vals[i], edge_vals[7 - i]);
   endtask

   task automatic test_random(input int count);
      logic [15:0] xr, yr;
      int m;
      for (int i = 0; i < count; i++) begin
         m = $urandom_range(0, 9);
         if (m < 5) begin
            xr = 16'($urandom); yr = 16'($urandom);
         end else if (m < 7) begin
            xr = 16'($urandom_range(0, 511) - 256);
            yr = 16'($urandom_range(0, 511) - 256);
         end else if (m < 9) begin
            xr = 16'($urandom); yr = $urandom_range(0, 1) ? xr : -xr;   // diagonals
         end else begin
            xr = $urandom_range(0, 1) ? 16'($urandom) : 16'h0;
            yr = (xr == 16'h0) ? 16'($urandom) : 16'h0;
         end
         send_sample(1'($urandom_range(0, 1)), xr, yr);
      end
   endtask

   task automatic test_deadzone_settings();
      logic [14:0] settings [4] = '{15'd0, 15'd32766, 15'd32767, 15'd100};
      for (int k = 0; k < 4; k++) begin
         write_reg(REG_LEFT_DZ, settings[k]);
         write_reg(REG_RIGHT_DZ, settings[3 - k]);
         send_sample(1'b0, 16'h7FFF, 16'h0001);
         send_sample(1'b1, 16'h8000, 16'h8000);
         send_sample(1'b0, 16'h0000, 16'h0000);
         test_random(60);
         drain();
      end
      write_reg(REG_LEFT_DZ, 15'($urandom_range(0, 32766)));
      write_reg(REG_RIGHT_DZ, 15'($urandom_range(0, 32766)));
      test_random(200);
      drain();
   endtask

   initial begin
      dz_left = LEFT_DZ_RESET;
      dz_right = RIGHT_DZ_RESET;
      foreach (prev_dir[i]) prev_dir[i] = DIR_CENTER;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300);
      drain();   // sender holds off until every result is back
      test_deadzone_settings();
      test_random(700);
      drain();
      $display("covered %0d samples, %0d results checked, %0d inside the deadzone",
               beats_sent, beats_checked, inside_seen);
      $display("deadzone settings swept from zero to the top, both sticks");
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

// ===== joystick_radial_deadzone.f =====
hw/rtl/jrd_pkg.sv
hw/rtl/joystick_radial_deadzone.sv
tb/joystick_radial_deadzone_test.sv
